/* hdl/trial_division_prime_test_macros.svh */
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// same-cycle implication, disabled in reset
`define TDP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tdp: same-cycle check failed");

// next-cycle implication, disabled in reset
`define TDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tdp: next-cycle check failed");

`endif

/* hdl/tdp_pkg.sv */
package tdp_pkg;

    localparam int NUM_W = 32;
    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH + 1);

    localparam logic [WIDTH-1:0] C_ZERO  = WIDTH'(0);
    localparam logic [WIDTH-1:0] C_ONE   = WIDTH'(1);
    localparam logic [WIDTH-1:0] C_FOUR  = WIDTH'(4);
    localparam logic [WIDTH-1:0] C_TWO   = WIDTH'(2);
    localparam logic [WIDTH-1:0] C_THREE = WIDTH'(3);
    localparam logic [WIDTH-1:0] C_FIVE  = WIDTH'(5);
    localparam logic [WIDTH-1:0] C_SIX   = WIDTH'(6);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD6,
        S_DIV_A,
        S_DIV_B,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [WIDTH-1:0] quo;
        logic [WIDTH-1:0] rem;
    } t_div_res;

endpackage

/* hdl/tdp_div.sv */
module tdp_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [tdp_pkg::WIDTH-1:0] i_dividend,
    input  logic [tdp_pkg::WIDTH-1:0] i_divisor,
    output tdp_pkg::t_div_res        o_res
);
    import tdp_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_dvs, n_dvs;
    logic [WIDTH:0]   w_shift;
    logic [WIDTH+1:0] w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = !w_diff[WIDTH+1];

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_cnt = CNT_W'(WIDTH);
            n_quo = i_dividend;
            n_rem = C_ZERO;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
            n_quo  = {r_quo[WIDTH-2:0], w_ge};
            n_rem  = w_ge ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_res.busy = (r_cnt != '0);
    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

/* hdl/trial_division_prime_test.sv */
// Numbers 0..3 are decided directly and go to the output register; otherwise
// each remainder is computed on the shared radix-2 divider, one for n mod 6
// plus up to two per divisor pair, then the result goes into the output register.
// Worst case for WIDTH = 32 is about 21850 remainders.
// One number at a time; a new beat is taken once the previous result is in
// the output register. Synchronous active-low reset empties the block.
module trial_division_prime_test (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [tdp_pkg::NUM_W-1:0] i_number,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_prime_flag
);
    import tdp_pkg::*;
    `include "trial_division_prime_test_macros.svh"

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_num, n_num;
    logic [WIDTH-1:0] r_d, n_d;
    logic             r_res, n_res;
    logic             r_out_valid, n_out_valid;
    logic             r_flag, n_flag;

    logic             w_in_acc;
    logic [WIDTH-1:0] w_num;
    logic             w_div_start;
    logic [WIDTH-1:0] w_div_dvs;
    logic [WIDTH-1:0] w_div_dnd;
    t_div_res         w_div;
    logic             w_out_free;

    assign w_num      = WIDTH'(i_number);
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_div_dnd  = (r_state == S_IDLE) ? w_num : r_num;

    tdp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dnd),
        .i_divisor  (w_div_dvs),
        .o_res      (w_div)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (w_num < C_FOUR) ? S_DONE : S_MOD6;
                end
            end
            S_MOD6: begin
                if (w_div.done) begin
                    n_state = (w_div.rem == C_ONE || w_div.rem == C_FIVE) ? S_DIV_A : S_DONE;
                end
            end
            S_DIV_A: begin
                if (w_div.done) begin
                    n_state = (r_d > w_div.quo || w_div.rem == C_ZERO) ? S_DONE : S_DIV_B;
                end
            end
            S_DIV_B: begin
                if (w_div.done) begin
                    n_state = (w_div.rem == C_ZERO) ? S_DONE : S_DIV_A;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_num       = r_num;
        n_d         = r_d;
        n_res       = r_res;
        w_div_start = 1'b0;
        w_div_dvs   = r_d;
        unique case (r_state)
            S_IDLE: begin
                w_div_dvs = C_SIX;
                if (w_in_acc) begin
                    n_num       = w_num;
                    n_d         = C_FIVE;
                    n_res       = (w_num == C_TWO || w_num == C_THREE);
                    w_div_start = !(w_num < C_FOUR);
                end
            end
            S_MOD6: begin
                if (w_div.done) begin
                    n_res       = 1'b0;
                    w_div_start = (w_div.rem == C_ONE || w_div.rem == C_FIVE);
                end
            end
            S_DIV_A: begin
                w_div_dvs = r_d + C_TWO;
                if (w_div.done) begin
                    if (r_d > w_div.quo) begin
                        n_res = 1'b1;
                    end else if (w_div.rem == C_ZERO) begin
                        n_res = 1'b0;
                    end else begin
                        w_div_start = 1'b1;
                    end
                end
            end
            S_DIV_B: begin
                w_div_dvs = r_d + C_SIX;
                if (w_div.done) begin
                    if (w_div.rem == C_ZERO) begin
                        n_res = 1'b0;
                    end else begin
                        n_d         = r_d + C_SIX;
                        w_div_start = 1'b1;
                    end
                end
            end
            S_DONE: begin
                n_res = r_res;
            end
            default: n_res = r_res;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_flag      = r_flag;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_DONE && w_out_free) begin
            n_out_valid = 1'b1;
            n_flag      = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_num  <= n_num;
        r_d    <= n_d;
        r_res  <= n_res;
        r_flag <= n_flag;
    end

    assign o_out_valid  = r_out_valid;
    assign o_prime_flag = r_flag;

    `TDP_ASSERT_IMPL(a_start_idle, w_div_start, !w_div.busy)
    `TDP_ASSERT_NEXT(a_small_direct, w_in_acc && w_num < C_FOUR, r_state == S_DONE)
    `TDP_ASSERT_IMPL(a_div_latency, w_div_start, ##(WIDTH + 1) w_div.done)

endmodule
